// ===== hw/rtl/lavm_pkg.sv =====
package lavm_pkg;

  localparam int UNIT_SHIFT = 30;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  typedef logic signed [31:0] fix_t;
  typedef logic signed [63:0] wide_t;
  typedef logic signed [65:0] acc_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
  } vec_t;

  typedef enum logic [1:0] {
    COL_RIGHT = 2'd0,
    COL_UP    = 2'd1,
    COL_LOOK  = 2'd2
  } col_t;

  localparam acc_t OFF_ROUND = acc_t'(64'sd1 <<< (UNIT_SHIFT - 1));
  localparam acc_t OFF_MAX   = acc_t'(64'sd2147483647);
  localparam acc_t OFF_MIN   = acc_t'(-64'sd2147483648);

  function automatic wide_t smul(fix_t a, fix_t b);
    return wide_t'(a) * wide_t'(b);
  endfunction

endpackage

// ===== hw/rtl/lavm_norm.sv =====
module lavm_norm import lavm_pkg::*; #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  wide_t         in_x,
  input  wide_t         in_y,
  input  wide_t         in_z,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output vec_t          unit,
  output logic          zero,
  output logic [SW-1:0] out_side
);

  logic [2:0][63:0] mag_in;
  logic [2:0]       sgn_in;
  logic [63:0]      orv;
  logic [7:0]       bnz;
  logic [7:0][2:0]  bidx;

  always_comb begin
    mag_in[0] = in_x[63] ? 64'(~in_x + 64'sd1) : 64'(in_x);
    mag_in[1] = in_y[63] ? 64'(~in_y + 64'sd1) : 64'(in_y);
    mag_in[2] = in_z[63] ? 64'(~in_z + 64'sd1) : 64'(in_z);
    sgn_in    = {in_z[63], in_y[63], in_x[63]};
    orv       = mag_in[0] | mag_in[1] | mag_in[2];
    for (int b = 0; b < 8; b++) begin
      bnz[b]  = |orv[8*b +: 8];
      bidx[b] = 3'd0;
      for (int j = 0; j < 8; j++) begin
        if (orv[8*b + j]) begin
          bidx[b] = 3'(j);
        end
      end
    end
  end

  logic             a_valid;
  logic [2:0][63:0] a_mag;
  logic [2:0]       a_sgn;
  logic [7:0]       a_bnz;
  logic [7:0][2:0]  a_bidx;
  logic [SW-1:0]    a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag  <= mag_in;
      a_sgn  <= sgn_in;
      a_bnz  <= bnz;
      a_bidx <= bidx;
      a_side <= in_side;
    end
  end

  logic [2:0] hb;
  logic [6:0] blen;

  always_comb begin
    hb = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (a_bnz[b]) begin
        hb = 3'(b);
      end
    end
    blen = (a_bnz == 8'd0) ? 7'd0 : {1'b0, hb, a_bidx[hb]} + 7'd1;
  end

  logic             b_valid;
  logic [2:0][63:0] b_mag;
  logic [2:0]       b_sgn;
  logic [6:0]       b_len;
  logic             b_zero;
  logic [SW-1:0]    b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mag  <= a_mag;
      b_sgn  <= a_sgn;
      b_len  <= blen;
      b_zero <= (a_bnz == 8'd0);
      b_side <= a_side;
    end
  end

  logic [2:0][29:0] shm;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_len > 7'd30) begin
        shm[i] = 30'(b_mag[i] >> (b_len - 7'd30));
      end else begin
        shm[i] = 30'(b_mag[i] << (7'd30 - b_len));
      end
    end
  end

  logic             c_valid;
  logic [2:0][29:0] c_m;
  logic [2:0]       c_sgn;
  logic             c_zero;
  logic [SW-1:0]    c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_m    <= shm;
      c_sgn  <= b_sgn;
      c_zero <= b_zero;
      c_side <= b_side;
    end
  end

  logic             d_valid;
  logic [2:0][59:0] d_sq;
  logic [2:0][29:0] d_m;
  logic [2:0]       d_sgn;
  logic             d_zero;
  logic [SW-1:0]    d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_sq[i] <= 60'(c_m[i]) * 60'(c_m[i]);
      end
      d_m    <= c_m;
      d_sgn  <= c_sgn;
      d_zero <= c_zero;
      d_side <= c_side;
    end
  end

  logic             sq_valid [SQRT_STEPS+1];
  logic [63:0]      sq_n     [SQRT_STEPS+1];
  logic [63:0]      sq_r     [SQRT_STEPS+1];
  logic [2:0][29:0] sq_m     [SQRT_STEPS+1];
  logic [2:0]       sq_sgn   [SQRT_STEPS+1];
  logic             sq_zero  [SQRT_STEPS+1];
  logic [SW-1:0]    sq_side  [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_n[0]    <= 64'(d_sq[0]) + 64'(d_sq[1]) + 64'(d_sq[2]);
      sq_r[0]    <= 64'd0;
      sq_m[0]    <= d_m;
      sq_sgn[0]  <= d_sgn;
      sq_zero[0] <= d_zero;
      sq_side[0] <= d_side;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
    logic [63:0] trial;

    assign trial = sq_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else if (en) begin
        sq_valid[k+1] <= sq_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_n[k] >= trial) begin
          sq_n[k+1] <= sq_n[k] - trial;
          sq_r[k+1] <= (sq_r[k] >> 1) + BIT;
        end else begin
          sq_n[k+1] <= sq_n[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
        sq_m[k+1]    <= sq_m[k];
        sq_sgn[k+1]  <= sq_sgn[k];
        sq_zero[k+1] <= sq_zero[k];
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  logic             dv_valid [DIV_STEPS+1];
  logic [2:0][61:0] dv_rem   [DIV_STEPS+1];
  logic [2:0][30:0] dv_q     [DIV_STEPS+1];
  logic [30:0]      dv_len   [DIV_STEPS+1];
  logic [2:0]       dv_sgn   [DIV_STEPS+1];
  logic             dv_zero  [DIV_STEPS+1];
  logic [SW-1:0]    dv_side  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= sq_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= 62'({sq_m[SQRT_STEPS][i], 30'd0}) + 62'(sq_r[SQRT_STEPS][31:1]);
        dv_q[0][i]   <= 31'd0;
      end
      dv_len[0]  <= sq_r[SQRT_STEPS][30:0];
      dv_sgn[0]  <= sq_sgn[SQRT_STEPS];
      dv_zero[0] <= sq_zero[SQRT_STEPS];
      dv_side[0] <= sq_side[SQRT_STEPS];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - k;
    logic [61:0] dd;

    assign dd = 62'(dv_len[k]) << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (en) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[k][i] >= dd) begin
            dv_rem[k+1][i] <= dv_rem[k][i] - dd;
            dv_q[k+1][i]   <= dv_q[k][i] | (31'd1 << SH);
          end else begin
            dv_rem[k+1][i] <= dv_rem[k][i];
            dv_q[k+1][i]   <= dv_q[k][i];
          end
        end
        dv_len[k+1]  <= dv_len[k];
        dv_sgn[k+1]  <= dv_sgn[k];
        dv_zero[k+1] <= dv_zero[k];
        dv_side[k+1] <= dv_side[k];
      end
    end
  end

  fix_t uq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[DIV_STEPS]) begin
        uq[i] = '0;
      end else if (dv_sgn[DIV_STEPS][i]) begin
        uq[i] = fix_t'(~{1'b0, dv_q[DIV_STEPS][i]} + 32'd1);
      end else begin
        uq[i] = fix_t'({1'b0, dv_q[DIV_STEPS][i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit.x   <= uq[0];
      unit.y   <= uq[1];
      unit.z   <= uq[2];
      zero     <= dv_zero[DIV_STEPS];
      out_side <= dv_side[DIV_STEPS];
    end
  end

endmodule

// ===== hw/rtl/look_at_view_matrix_unit.sv =====
// Channel  Dir  Width  Contents
// s_*      in   288    eye x,y,z / target x,y,z / up x,y,z, Q16.16 each
// m_*      out  136    column, axis x,y,z (Q2.30), offset; tlast, tuser=degenerate
//
// Three beats per accepted item, one per cycle while m_tready holds high.
// An item runs through three normalizers (encoder, shift, squares, 32-step
// square root, 31-step divider) plus cross and dot stages. Sustained
// throughput is set by the output beats; new items enter while earlier ones
// are still in flight. Reset is synchronous. While the last stage holds an
// item, a busy output stalls every stage at once; nothing is dropped or repeated.
module look_at_view_matrix_unit import lavm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,   // eye_x, eye_y, eye_z, target_x, target_y, target_z,
                                  // up_x, up_y, up_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // column_index, axis_x, axis_y, axis_z, offset, pad
  output logic         m_tlast,
  output logic [0:0]   m_tuser    // degenerate
);

  logic adv;
  logic ser_free;

  logic  v0;
  vec_t  eye0, up0;
  wide_t d0x, d0y, d0z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eye0 <= {s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]};
      up0  <= {s_tdata[223:192], s_tdata[255:224], s_tdata[287:256]};
      d0x  <= 64'($signed(s_tdata[127:96]))  - 64'($signed(s_tdata[31:0]));
      d0y  <= 64'($signed(s_tdata[159:128])) - 64'($signed(s_tdata[63:32]));
      d0z  <= 64'($signed(s_tdata[191:160])) - 64'($signed(s_tdata[95:64]));
    end
  end

  logic         n1_valid, n1_zero;
  vec_t         n1_unit, n1_up, n1_eye;
  logic [191:0] n1_side;

  lavm_norm #(.SW(192)) u_norm_look (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v0),
    .in_x     (d0x),
    .in_y     (d0y),
    .in_z     (d0z),
    .in_side  ({up0, eye0}),
    .out_valid(n1_valid),
    .unit     (n1_unit),
    .zero     (n1_zero),
    .out_side (n1_side)
  );

  assign {n1_up, n1_eye} = n1_side;

  logic v1, deg1;
  vec_t look1, up1, eye1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= n1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      look1.x <= fix_t'(-n1_unit.x);
      look1.y <= fix_t'(-n1_unit.y);
      look1.z <= fix_t'(-n1_unit.z);
      up1     <= n1_up;
      eye1    <= n1_eye;
      deg1    <= n1_zero;
    end
  end

  logic  v2, deg2;
  vec_t  look2, eye2;
  wide_t p2 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2[0] <= smul(up1.y, look1.z);
      p2[1] <= smul(up1.z, look1.y);
      p2[2] <= smul(up1.z, look1.x);
      p2[3] <= smul(up1.x, look1.z);
      p2[4] <= smul(up1.x, look1.y);
      p2[5] <= smul(up1.y, look1.x);
      look2 <= look1;
      eye2  <= eye1;
      deg2  <= deg1;
    end
  end

  logic  v3, deg3;
  vec_t  look3, eye3;
  wide_t c3x, c3y, c3z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3x   <= p2[0] - p2[1];
      c3y   <= p2[2] - p2[3];
      c3z   <= p2[4] - p2[5];
      look3 <= look2;
      eye3  <= eye2;
      deg3  <= deg2;
    end
  end

  logic         n2_valid, n2_zero, n2_deg;
  vec_t         n2_unit, n2_look, n2_eye;
  logic [192:0] n2_side;

  lavm_norm #(.SW(193)) u_norm_right (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v3),
    .in_x     (c3x),
    .in_y     (c3y),
    .in_z     (c3z),
    .in_side  ({deg3, look3, eye3}),
    .out_valid(n2_valid),
    .unit     (n2_unit),
    .zero     (n2_zero),
    .out_side (n2_side)
  );

  assign {n2_deg, n2_look, n2_eye} = n2_side;

  logic  v4, deg4;
  vec_t  look4, rt4, eye4;
  wide_t p4 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= n2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4[0] <= smul(n2_look.y, n2_unit.z);
      p4[1] <= smul(n2_look.z, n2_unit.y);
      p4[2] <= smul(n2_look.z, n2_unit.x);
      p4[3] <= smul(n2_look.x, n2_unit.z);
      p4[4] <= smul(n2_look.x, n2_unit.y);
      p4[5] <= smul(n2_look.y, n2_unit.x);
      look4 <= n2_look;
      rt4   <= n2_unit;
      eye4  <= n2_eye;
      deg4  <= n2_deg | n2_zero;
    end
  end

  logic  v5, deg5;
  vec_t  look5, rt5, eye5;
  wide_t c5x, c5y, c5z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c5x   <= p4[0] - p4[1];
      c5y   <= p4[2] - p4[3];
      c5z   <= p4[4] - p4[5];
      look5 <= look4;
      rt5   <= rt4;
      eye5  <= eye4;
      deg5  <= deg4;
    end
  end

  logic         n3_valid, n3_zero, n3_deg;
  vec_t         n3_unit, n3_rt, n3_look, n3_eye;
  logic [288:0] n3_side;

  lavm_norm #(.SW(289)) u_norm_up (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v5),
    .in_x     (c5x),
    .in_y     (c5y),
    .in_z     (c5z),
    .in_side  ({deg5, rt5, look5, eye5}),
    .out_valid(n3_valid),
    .unit     (n3_unit),
    .zero     (n3_zero),
    .out_side (n3_side)
  );

  assign {n3_deg, n3_rt, n3_look, n3_eye} = n3_side;

  vec_t ax_in [3];

  assign ax_in[0] = n3_rt;
  assign ax_in[1] = n3_unit;
  assign ax_in[2] = n3_look;

  logic  v6, deg6;
  vec_t  ax6 [3];
  wide_t pe6 [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= n3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        pe6[c][0] <= smul(n3_eye.x, ax_in[c].x);
        pe6[c][1] <= smul(n3_eye.y, ax_in[c].y);
        pe6[c][2] <= smul(n3_eye.z, ax_in[c].z);
        ax6[c]    <= ax_in[c];
      end
      deg6 <= n3_deg | n3_zero;
    end
  end

  logic v7, deg7;
  vec_t ax7 [3];
  acc_t t7  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        t7[c]  <= OFF_ROUND - (acc_t'(pe6[c][0]) + acc_t'(pe6[c][1]) + acc_t'(pe6[c][2]));
        ax7[c] <= ax6[c];
      end
      deg7 <= deg6;
    end
  end

  logic v8, deg8;
  vec_t ax8  [3];
  fix_t off8 [3];
  acc_t q7   [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q7[c] = t7[c] >>> UNIT_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        if (q7[c] > OFF_MAX) begin
          off8[c] <= fix_t'(OFF_MAX);
        end else if (q7[c] < OFF_MIN) begin
          off8[c] <= fix_t'(OFF_MIN);
        end else begin
          off8[c] <= fix_t'(q7[c]);
        end
        ax8[c] <= ax7[c];
      end
      deg8 <= deg7;
    end
  end

  logic ovalid;
  col_t cnt, cnt_next;
  vec_t hold_ax  [3];
  fix_t hold_off [3];
  logic hold_deg;
  vec_t sel_ax;
  fix_t sel_off;

  assign ser_free = !ovalid || (m_tready && cnt == COL_LOOK);
  assign adv      = !v8 || ser_free;
  assign s_tready = adv;

  always_comb begin
    unique case (cnt)
      COL_RIGHT: cnt_next = COL_UP;
      COL_UP:    cnt_next = COL_LOOK;
      default:   cnt_next = COL_RIGHT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      cnt    <= COL_RIGHT;
    end else if (adv && v8) begin
      ovalid <= 1'b1;
      cnt    <= COL_RIGHT;
    end else if (ovalid && m_tready) begin
      if (cnt == COL_LOOK) begin
        ovalid <= 1'b0;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v8) begin
      hold_ax  <= ax8;
      hold_off <= off8;
      hold_deg <= deg8;
    end
  end

  always_comb begin
    unique case (cnt)
      COL_RIGHT: begin
        sel_ax  = hold_ax[0];
        sel_off = hold_off[0];
      end
      COL_UP: begin
        sel_ax  = hold_ax[1];
        sel_off = hold_off[1];
      end
      default: begin
        sel_ax  = hold_ax[2];
        sel_off = hold_off[2];
      end
    endcase
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = {6'd0, sel_off, sel_ax.z, sel_ax.y, sel_ax.x, cnt};
  assign m_tlast  = (cnt == COL_LOOK);
  assign m_tuser  = hold_deg;

endmodule

// ===== hw/rtl/lavm_checker.sv =====
module lavm_props import lavm_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic         m_tlast,
  input logic [0:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[1:0] == COL_LOOK)))
    else $error("tlast does not match look column");

  a_cont: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a matrix");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tdata[1:0] == COL_RIGHT) |=> (m_tdata[1:0] == COL_UP))
    else $error("up column does not follow right column");

  a_deg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> $stable(m_tuser))
    else $error("degenerate flag changed inside a matrix");

endmodule

bind look_at_view_matrix_unit lavm_props u_lavm_props (.*);

// ===== bench/lavm_checker.sv =====
`timescale 1ns / 1ps

module lavm_checker import lavm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [287:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [135:0] m_tdata,
  input  logic         m_tlast,
  input  logic [0:0]   m_tuser,
  output int           errors,
  output int           pending,
  output int           columns_checked,
  output int           degenerate_seen
);

  typedef longint trio_t [3];

  typedef struct {
    col_t col;
    fix_t ax;
    fix_t ay;
    fix_t az;
    fix_t off;
    logic last;
    logic degen;
  } column_t;

  column_t column_q[$];

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // returns 1 when the vector has zero length
  function automatic bit unit_vec(input trio_t v, output trio_t u);
    longint unsigned m [3];
    longint unsigned mx, sum, len, q;
    int bits;
    mx = 0;
    sum = 0;
    bits = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? 64'd0 - longint'(v[i]) : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1;
    end
    while (bits < 64 && (mx >> bits) != 0) bits++;
    for (int i = 0; i < 3; i++) begin
      if (bits > UNIT_SHIFT) m[i] = m[i] >> (bits - UNIT_SHIFT);
      else m[i] = m[i] << (UNIT_SHIFT - bits);
      sum = sum + m[i] * m[i];
    end
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << UNIT_SHIFT) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 0;
  endfunction

  function automatic trio_t cross3(trio_t a, trio_t b);
    trio_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic fix_t view_offset(trio_t eye, trio_t ax);
    longint s;
    s = -(eye[0] * ax[0] + eye[1] * ax[1] + eye[2] * ax[2]);
    s = (s + (64'sd1 <<< (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return fix_t'(s);
  endfunction

  task automatic predict_columns(logic [287:0] d);
    trio_t eye, tgt, upv, dir, look, rt, up2;
    trio_t axes [3];
    bit degen;
    column_t c;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(d[32*i +: 32]));
      tgt[i] = longint'($signed(d[32*(3+i) +: 32]));
      upv[i] = longint'($signed(d[32*(6+i) +: 32]));
      dir[i] = tgt[i] - eye[i];
    end
    degen = unit_vec(dir, look);
    for (int i = 0; i < 3; i++) look[i] = -look[i];
    if (unit_vec(cross3(upv, look), rt)) degen = 1;
    if (unit_vec(cross3(look, rt), up2)) degen = 1;
    axes[0] = rt;
    axes[1] = up2;
    axes[2] = look;
    for (int k = 0; k < 3; k++) begin
      c.col   = col_t'(k);
      c.ax    = fix_t'(axes[k][0]);
      c.ay    = fix_t'(axes[k][1]);
      c.az    = fix_t'(axes[k][2]);
      c.off   = view_offset(eye, axes[k]);
      c.last  = (k == 2);
      c.degen = degen;
      column_q.push_back(c);
    end
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    columns_checked = 0;
    degenerate_seen = 0;
  end

  always @(posedge clk) begin
    column_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_columns(s_tdata);
      if (m_tvalid && m_tready) begin
        if (column_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
        end else begin
          e = column_q.pop_front();
          compare_field("column", 32'(e.col), 32'(m_tdata[1:0]));
          compare_field("axis_x", e.ax, m_tdata[33:2]);
          compare_field("axis_y", e.ay, m_tdata[65:34]);
          compare_field("axis_z", e.az, m_tdata[97:66]);
          compare_field("offset", e.off, m_tdata[129:98]);
          compare_field("last", 32'(e.last), 32'(m_tlast));
          compare_field("degenerate", 32'(e.degen), 32'(m_tuser[0]));
          columns_checked++;
          if (e.degen) degenerate_seen++;
        end
      end
    end
    pending = column_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lavm_pkg::*;

  localparam int RANDOM_ITEMS = 340;
  localparam int CYCLE_LIMIT  = 300000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [135:0] m_tdata;
  logic         m_tlast;
  logic [0:0]   m_tuser;

  int errors, pending, columns_checked, degenerate_seen;
  int cycles = 0;
  logic [287:0] item_q[$];

  look_at_view_matrix_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  lavm_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .errors(errors), .pending(pending),
    .columns_checked(columns_checked), .degenerate_seen(degenerate_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("look_at_view_matrix_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [287:0] pack_item(fix_t ex, fix_t ey, fix_t ez, fix_t tx, fix_t ty,
                                             fix_t tz, fix_t ux, fix_t uy, fix_t uz);
    return {uz, uy, ux, tz, ty, tx, ez, ey, ex};
  endfunction

  function automatic fix_t rnd_fix(int mode);
    case (mode)
      0: return fix_t'($urandom);
      1: return fix_t'(int'($urandom_range(0, 2 ** 25)) - 2 ** 24);
      default: return fix_t'(int'($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  task automatic build_stimulus();
    fix_t one, mx, mn;
    fix_t e [3];
    fix_t t [3];
    fix_t u [3];
    int mode, pick, k;
    one = 32'sd65536;
    mx  = 32'sh7fffffff;
    mn  = 32'sh80000000;
    item_q.push_back(pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
    item_q.push_back(pack_item(0, 0, 5*one, 0, 0, 0, 0, one, 0));
    item_q.push_back(pack_item(one, 2*one, 3*one, one, 2*one, 3*one, 0, one, 0));
    item_q.push_back(pack_item(0, 0, 0, 0, 0, -one, 0, 0, 3*one));
    item_q.push_back(pack_item(0, 0, 0, 0, one, 0, 0, 0, 0));
    item_q.push_back(pack_item(mx, mx, mx, mn, mn, mn, mx, mn, mx));
    item_q.push_back(pack_item(mn, mn, mn, mx, mx, mx, mn, mx, mn));
    item_q.push_back(pack_item(mx, mn, mx, mn, mx, mn, 0, mx, 0));
    item_q.push_back(pack_item(mn, 0, 0, mx, 0, 0, 0, mn, 0));
    item_q.push_back(pack_item(mx, mx, mx, mx, mx, mx, one, 0, 0));
    item_q.push_back(pack_item(mx, mx, mx, 0, 0, 0, 0, one, 0));
    item_q.push_back(pack_item(mn, mn, mn, 0, 0, 0, 0, 0, one));
    item_q.push_back(pack_item(1, 0, 0, 0, 0, 0, 0, 1, 0));
    item_q.push_back(pack_item(0, 0, 0, 1, 1, 1, -1, 1, 0));
    item_q.push_back(pack_item(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    item_q.push_back(pack_item(3*one, 4*one, 5*one, 0, one, 0, mx, mx, mn));
    item_q.push_back(pack_item(0, 10*one, 0, 0, 0, 0, 0, 0, -one));
    item_q.push_back(pack_item(one, 0, 0, 2*one, one, 0, 0, 0, mx));
    item_q.push_back(pack_item(-7*one, 2*one, 9*one, one, -one, one, 0, one, 0));
    item_q.push_back(pack_item(12345, -6789, 101112, -1314, 151617, -18, 1, mx, 1));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      mode = $urandom_range(0, 2);
      pick = $urandom_range(0, 19);
      for (int j = 0; j < 3; j++) begin
        e[j] = rnd_fix(mode);
        t[j] = rnd_fix(mode);
        u[j] = rnd_fix($urandom_range(0, 2));
      end
      if (pick == 0) begin
        t = e;
      end else if (pick == 1) begin
        k = int'($urandom_range(1, 8)) - 4;
        for (int j = 0; j < 3; j++) begin
          e[j] = rnd_fix(1);
          t[j] = rnd_fix(1);
          u[j] = fix_t'(k * (t[j] - e[j]));
        end
      end else if (pick < 8) begin
        u[0] = rnd_fix(2);
        u[1] = one + rnd_fix(2);
        u[2] = rnd_fix(2);
      end
      item_q.push_back(pack_item(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]));
    end
  endtask

  // receiver: switch stall pattern at random among three modes, one long hold-off early on
  initial begin
    int mode, cyc;
    mode = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 200 == 0) mode = $urandom_range(0, 2);
      if (cyc >= 300 && cyc < 1100) m_tready <= 0;
      else if (mode == 0) m_tready <= 1;
      else if (mode == 1) m_tready <= $urandom_range(0, 1);
      else m_tready <= ($urandom_range(0, 9) != 0);
    end
  end

  initial begin
    int burst, gap, n_items, wait_cycles;
    burst = 0;
    build_stimulus();
    n_items = item_q.size();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (item_q[i]) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          s_tvalid <= 0;
          repeat (gap) @(posedge clk);
        end
      end
      s_tvalid <= 1;
      s_tdata <= item_q[i];
      do @(posedge clk); while (!s_tready);
      burst--;
    end
    s_tvalid <= 0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (300) @(posedge clk);
    $display("Sent %0d view setups, checked %0d matrix columns", n_items, columns_checked);
    $display("Degenerate columns seen: %0d, still outstanding: %0d", degenerate_seen, pending);
    if (errors == 0 && pending == 0) begin
      $display("look_at_view_matrix_unit regression: pass");
    end else begin
      $display("look_at_view_matrix_unit regression: fail");
    end
    $finish;
  end

endmodule
